// File: rtl/core/pdnp_pkg.sv
`default_nettype none

package pdnp_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 17;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_STEREO        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDE_SAMPLES  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NO_SMOOTHING  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FIVE_BIT_MODE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_STEP     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTE_LIMIT    = 3'd5;

  localparam logic [16:0] ONE_Q16          = 17'h10000;
  localparam logic [16:0] RATE_STEP_RESET  = 17'd41557;
  localparam logic [15:0] BYTE_LIMIT_RESET = 16'd65534;
  localparam logic [15:0] BYTE_COUNT_MAX   = 16'hffff;
  localparam logic [7:0]  BIAS_8BIT        = 8'd127;
  localparam logic [7:0]  TERMINATOR       = 8'h00;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } frame_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } code_word_t;

  typedef struct packed {
    logic        stereo;
    logic        wide_samples;
    logic        no_smoothing;
    logic        five_bit_mode;
    logic [16:0] rate_step;
    logic [15:0] byte_limit;
  } cfg_regs_t;

  // One queued result: a packed byte, or a flush that expands to two words.
  typedef struct packed {
    logic       flush;
    logic [7:0] data;
  } q_entry_t;

endpackage

`default_nettype wire

// File: rtl/core/pdnp_frame.sv
`default_nettype none

module pdnp_frame (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  accept,
  input  pdnp_pkg::frame_word_t frame_word,
  input  pdnp_pkg::cfg_regs_t  cfg,
  output logic                 push,
  output pdnp_pkg::q_entry_t   push_entry
);

  logic signed [15:0] mix_value, mix_value_next;
  logic [16:0]        phase_acc, phase_acc_next;
  logic [7:0]         pack_byte, pack_byte_next;
  logic               low_half_next, low_half_next_next;
  logic [15:0]        bytes_out, bytes_out_next;
  logic               halted, halted_next;

  logic signed [16:0] left_ext, right_ext, pair_sum, pair_adj;
  logic signed [15:0] frame_val, mix_new, bias_sum;
  logic signed [16:0] mix_sum, mix_adj;
  logic [7:0]         sample8, quot;
  logic [16:0]        step;
  logic [17:0]        phase_sum;
  logic               keep;
  logic [15:0]        bytes_inc;

  always_comb begin
    if (cfg.wide_samples) begin
      left_ext  = {frame_word.left_sample[15], frame_word.left_sample};
      right_ext = {frame_word.right_sample[15], frame_word.right_sample};
    end else begin
      left_ext  = {9'b0, frame_word.left_sample[7:0]};
      right_ext = {9'b0, frame_word.right_sample[7:0]};
    end

    // halve toward zero: add one to negatives before the shift
    pair_sum  = left_ext + right_ext;
    pair_adj  = pair_sum + {16'b0, pair_sum[16]};
    frame_val = cfg.stereo ? pair_adj[16:1] : left_ext[15:0];

    mix_sum = {mix_value[15], mix_value} + {frame_val[15], frame_val};
    mix_adj = mix_sum + {16'b0, mix_sum[16]};
    mix_new = cfg.no_smoothing ? frame_val : mix_adj[16:1];

    // divide by 256 toward zero, then bias
    bias_sum = mix_new + (mix_new[15] ? 16'sd255 : 16'sd0);
    quot     = bias_sum[15:8];
    sample8  = cfg.wide_samples ? 8'(quot + pdnp_pkg::BIAS_8BIT) : mix_new[7:0];

    step      = (cfg.rate_step > pdnp_pkg::ONE_Q16) ? pdnp_pkg::ONE_Q16 : cfg.rate_step;
    phase_sum = {1'b0, phase_acc} + {1'b0, step};
    keep      = (phase_sum >= {1'b0, pdnp_pkg::ONE_Q16});

    bytes_inc = (bytes_out == pdnp_pkg::BYTE_COUNT_MAX) ? bytes_out : bytes_out + 16'd1;

    mix_value_next     = mix_value;
    phase_acc_next     = phase_acc;
    pack_byte_next     = pack_byte;
    low_half_next_next = low_half_next;
    bytes_out_next     = bytes_out;
    halted_next        = halted;
    push               = 1'b0;
    push_entry.flush   = 1'b0;
    push_entry.data    = pack_byte;

    if (accept) begin
      if (frame_word.cmd == pdnp_pkg::CMD_FLUSH) begin
        push               = 1'b1;
        push_entry.flush   = 1'b1;
        push_entry.data    = pack_byte;
        mix_value_next     = '0;
        phase_acc_next     = '0;
        pack_byte_next     = '0;
        low_half_next_next = 1'b0;
        bytes_out_next     = '0;
        halted_next        = 1'b0;
      end else if (!halted) begin
        mix_value_next = mix_new;
        phase_acc_next = keep ? 17'(phase_sum - {1'b0, pdnp_pkg::ONE_Q16}) : phase_sum[16:0];
        if (keep) begin
          if (cfg.five_bit_mode) begin
            push            = 1'b1;
            push_entry.data = {3'b0, sample8[7:3]};
            pack_byte_next  = '0;
            bytes_out_next  = bytes_inc;
          end else if (!low_half_next) begin
            pack_byte_next     = {sample8[7:4], 4'b0};
            low_half_next_next = 1'b1;
          end else begin
            push               = 1'b1;
            push_entry.data    = {pack_byte[7:4], sample8[7:4]};
            pack_byte_next     = '0;
            low_half_next_next = 1'b0;
            bytes_out_next     = bytes_inc;
          end
        end
        halted_next = (bytes_out_next >= cfg.byte_limit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_value     <= '0;
      phase_acc     <= '0;
      pack_byte     <= '0;
      low_half_next <= 1'b0;
      bytes_out     <= '0;
      halted        <= 1'b0;
    end else begin
      mix_value     <= mix_value_next;
      phase_acc     <= phase_acc_next;
      pack_byte     <= pack_byte_next;
      low_half_next <= low_half_next_next;
      bytes_out     <= bytes_out_next;
      halted        <= halted_next;
    end
  end

  a_phase_below_one: assert property (@(posedge clk) disable iff (rst)
    phase_acc[16] == 1'b0)
    else $error("phase accumulator reached one after wrap");

  a_pending_low_clear: assert property (@(posedge clk) disable iff (rst)
    pack_byte[3:0] == 4'b0)
    else $error("pending byte has low nibble set");

  a_five_bit_range: assert property (@(posedge clk) disable iff (rst)
    (push && !push_entry.flush && cfg.five_bit_mode) |-> (push_entry.data[7:5] == 3'b0))
    else $error("five-bit sample out of range");

endmodule

`default_nettype wire

// File: rtl/core/pdnp_outq.sv
`default_nettype none

module pdnp_outq (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  pdnp_pkg::q_entry_t  push_entry,
  output logic                full,
  output logic                code_valid,
  input  wire                 code_stall,
  output pdnp_pkg::code_word_t code_word
);

  localparam int PTR_W = (pdnp_pkg::QUEUE_DEPTH > 1) ? $clog2(pdnp_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(pdnp_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(pdnp_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(pdnp_pkg::QUEUE_DEPTH);

  pdnp_pkg::q_entry_t mem [pdnp_pkg::QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             half;
  logic             pop, finish;
  pdnp_pkg::q_entry_t head;

  always_comb begin
    head       = mem[rd_ptr];
    full       = (count == FULL_CNT);
    code_valid = (count != '0);
    pop        = code_valid && !code_stall;
    // a flush entry stays at the head for its terminator word
    finish     = pop && !(head.flush && !half);
    code_word.last     = head.flush && half;
    code_word.out_byte = code_word.last ? pdnp_pkg::TERMINATOR : head.data;
    count_next = count + CNT_W'(push) - CNT_W'(finish);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      half   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (finish) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (pop) begin
        half <= head.flush && !half;
      end
      count <= count_next;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("word pushed into full queue");

  a_half_on_flush: assert property (@(posedge clk) disable iff (rst)
    half |-> (code_valid && head.flush))
    else $error("terminator phase without flush at head");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count overflow");

endmodule

`default_nettype wire

// File: rtl/core/pcm_downsample_nibble_packer_core.sv
`default_nettype none

// PCM down-sampler and 4-bit packer. Each frame word (mono or stereo, 8-bit
// unsigned or 16-bit signed) is mixed, optionally smoothed with the previous
// mix, decimated by a Q16 phase accumulator and reduced to 8 bits; kept
// samples are packed two nibbles per code word (high first) or sent one per
// word in five-bit mode. A flush command sends the pending byte and then a
// zero word with last set, and restarts the stream. One frame word is taken
// every cycle: all frame work is one combinational pass into a two-entry
// output queue, so frame_stall rises only when that queue is full; a flush
// holds the queue head for two code words. The user must write configuration
// (cfg_valid/cfg_ready, always ready) while the block is idle; not enforced.

module pcm_downsample_nibble_packer_core (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                frame_valid,
  output logic                               frame_stall,
  input  pdnp_pkg::frame_word_t              frame_word,
  output logic                               code_valid,
  input  wire                                code_stall,
  output pdnp_pkg::code_word_t               code_word,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [pdnp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire [pdnp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  pdnp_pkg::cfg_regs_t cfg;
  pdnp_pkg::q_entry_t  push_entry;
  logic                push, full, accept;

  assign cfg_ready   = 1'b1;
  assign frame_stall = full;
  assign accept      = frame_valid && !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stereo        <= 1'b0;
      cfg.wide_samples  <= 1'b0;
      cfg.no_smoothing  <= 1'b0;
      cfg.five_bit_mode <= 1'b0;
      cfg.rate_step     <= pdnp_pkg::RATE_STEP_RESET;
      cfg.byte_limit    <= pdnp_pkg::BYTE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pdnp_pkg::REG_STEREO:        cfg.stereo        <= cfg_data[0];
        pdnp_pkg::REG_WIDE_SAMPLES:  cfg.wide_samples  <= cfg_data[0];
        pdnp_pkg::REG_NO_SMOOTHING:  cfg.no_smoothing  <= cfg_data[0];
        pdnp_pkg::REG_FIVE_BIT_MODE: cfg.five_bit_mode <= cfg_data[0];
        pdnp_pkg::REG_RATE_STEP:     cfg.rate_step     <= cfg_data[16:0];
        pdnp_pkg::REG_BYTE_LIMIT:    cfg.byte_limit    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  pdnp_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .frame_word (frame_word),
    .cfg        (cfg),
    .push       (push),
    .push_entry (push_entry)
  );

  pdnp_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_word  (code_word)
  );

endmodule

`default_nettype wire
